@@ rtl/assert_macros.svh @@
// assertion helpers for the interpolation weight engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/liwe_pkg.sv @@
`default_nettype none

package liwe_pkg;

    localparam int TIME_W = 32;
    localparam int COL_W  = 6;
    localparam int WGT_W  = 17;
    localparam int POS_W  = 2;
    localparam int CFG_W  = 7;

    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

    // func codes carried in the input tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // position codes carried in the output tuser
    localparam logic [POS_W-1:0] POS_INTERIOR = 2'd0;
    localparam logic [POS_W-1:0] POS_CLAMP_LO = 2'd1;
    localparam logic [POS_W-1:0] POS_CLAMP_HI = 2'd2;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic [1:0]       pad;
        logic [WGT_W-1:0] upper_weight;
        logic [WGT_W-1:0] lower_weight;
        logic [COL_W-1:0] upper_col;
        logic [COL_W-1:0] lower_col;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/liwe_ram.sv @@
`default_nettype none

module liwe_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/linear_interp_weight_engine.sv @@
// linear interpolation weight engine
//
// channels: s_axis carries load and query beats (tuser = func), m_axis carries
// one result beat per query (tuser = position), cfg writes grid_points
// a load beat writes one grid slot in the accept cycle and gives no result;
// the block stays ready, so loads can follow back to back
// a query beat walks the grid store one slot per cycle through the single
// read port until it finds the first point at or above the query or reaches
// the last point in use; on an interior hit it then runs a restoring divider
// that yields one weight bit per cycle; a query passes the prime, scan,
// divide (interior hits only) and done states before its result is registered
// the block takes no new beat while a query is in flight
// a finished result sits in the output register; a stalled receiver holds
// it there and the block may still take load beats, but the next query
// waits in its final state until the register frees
// reset: asynchronous, active low; grid_points returns to 1, the grid store
// keeps no defined contents until loaded, no clearing pass is needed
// configuration is to be written only while the block is idle; the user must see to this, the block does not enforce it
`default_nettype none

`include "assert_macros.svh"

module linear_interp_weight_engine
    import liwe_pkg::*;
#(
    parameter int GRID_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration channel: grid_points
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    // input beats
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // grid_index[5:0], grid_time[37:6],
                                            // query_time[69:38], zero pad
    input  wire logic [0:0]  s_axis_tuser,  // func[0]
    // result beats
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // lower_col[5:0], upper_col[11:6],
                                            // lower_weight[28:12],
                                            // upper_weight[45:29], zero pad
    output logic [1:0]       m_axis_tuser   // position[1:0]
);

    localparam int ADDR_W = $clog2(GRID_DEPTH);
    localparam int LIM    = (GRID_DEPTH < 64) ? GRID_DEPTH : 64;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRIME = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [4:0] LAST_STEP = 5'd16;

    // input fields
    logic [COL_W-1:0]  in_grid_index;
    logic [TIME_W-1:0] in_grid_time;
    logic [TIME_W-1:0] in_query_time;

    assign in_grid_index = s_axis_tdata[5:0];
    assign in_grid_time  = s_axis_tdata[37:6];
    assign in_query_time = s_axis_tdata[69:38];

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] points_reg, points_next;
    logic             out_valid_reg, out_valid_next;

    // working payload
    logic [COL_W-1:0]  k_reg, k_next;
    logic [TIME_W-1:0] q_reg, q_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [WGT_W-1:0]  quo_reg, quo_next;
    logic [4:0]        step_reg, step_next;
    logic [COL_W-1:0]  lo_col_reg, lo_col_next;
    logic [COL_W-1:0]  up_col_reg, up_col_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    result_t           out_reg, out_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;

    // grid store port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [TIME_W-1:0] rd_data;

    logic              s_accept;
    logic [CFG_W-1:0]  n_use;
    logic              hit;
    logic              last_slot;
    logic [TIME_W-1:0] num_diff;
    logic [TIME_W-1:0] den_diff;
    logic [TIME_W:0]   trial;
    logic              ge;
    logic              out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // points in use: zero reads as one, saturate at the store size, at most 64
    always_comb
    begin
        if (points_reg == '0)
        begin
            n_use = 7'd1;
        end
        else if (points_reg > CFG_W'(LIM))
        begin
            n_use = CFG_W'(LIM);
        end
        else
        begin
            n_use = points_reg;
        end
    end

    // loads write straight into the store; slots past the depth are dropped
    assign wr_en   = s_accept && (s_axis_tuser[0] == FUNC_LOAD)
                     && (int'(in_grid_index) < GRID_DEPTH);
    assign wr_addr = ADDR_W'(in_grid_index);

    // prime reads slot 0, each scan cycle fetches the slot after the one compared
    assign rd_addr = (state_reg == ST_SCAN) ? ADDR_W'({1'b0, k_reg} + 7'd1) : '0;

    liwe_ram #(
        .WIDTH (TIME_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_grid_time),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // scan compare on the slot just read
    assign hit       = $signed(rd_data) >= $signed(q_reg);
    assign last_slot = ({1'b0, k_reg} == (n_use - 7'd1));

    // bracket differences, both positive and at most 2^32-1, so the
    // wrapped 32-bit difference is exact
    assign num_diff = q_reg - prev_reg;
    assign den_diff = rd_data - prev_reg;

    // divider step: first step has no shift (integer bit of the quotient)
    assign trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        state_next     = state_reg;
        points_next    = points_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        prev_next      = prev_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        lo_col_next    = lo_col_reg;
        up_col_next    = up_col_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_pos_next   = out_pos_reg;

        if (cfg_valid && cfg_ready)
        begin
            points_next = cfg_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && (s_axis_tuser[0] == FUNC_QUERY))
                begin
                    q_next     = in_query_time;
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                k_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit && (k_reg == '0))
                begin
                    lo_col_next = '0;
                    up_col_next = '0;
                    quo_next    = '0;
                    pos_next    = POS_CLAMP_LO;
                    state_next  = ST_DONE;
                end
                else if (hit)
                begin
                    lo_col_next = k_reg - 6'd1;
                    up_col_next = k_reg;
                    rem_next    = num_diff;
                    den_next    = den_diff;
                    quo_next    = '0;
                    step_next   = '0;
                    pos_next    = POS_INTERIOR;
                    state_next  = ST_DIV;
                end
                else if (last_slot)
                begin
                    lo_col_next = k_reg;
                    up_col_next = k_reg;
                    quo_next    = '0;
                    pos_next    = POS_CLAMP_HI;
                    state_next  = ST_DONE;
                end
                else
                begin
                    prev_next = rd_data;
                    k_next    = k_reg + 6'd1;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? TIME_W'(trial - {1'b0, den_reg}) : trial[TIME_W-1:0];
                quo_next  = {quo_reg[WGT_W-2:0], ge};
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next.pad          = '0;
                    out_next.lower_col    = lo_col_reg;
                    out_next.upper_col    = up_col_reg;
                    out_next.upper_weight = quo_reg;
                    out_next.lower_weight = ONE_Q16 - quo_reg;
                    out_pos_next          = pos_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            points_reg    <= 7'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            points_reg    <= points_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        q_reg       <= q_next;
        prev_reg    <= prev_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        lo_col_reg  <= lo_col_next;
        up_col_reg  <= up_col_next;
        pos_reg     <= pos_next;
        out_reg     <= out_next;
        out_pos_reg <= out_pos_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = out_pos_reg;

    // weights of a delivered result always add up to one
    `ASSERT_SAME(a_weight_sum, clk, rst_n, out_valid_reg,
        (out_reg.lower_weight + out_reg.upper_weight) == ONE_Q16,
        "result weights do not sum to one")

    // a clamped result has one column with all the weight
    `ASSERT_SAME(a_clamp_shape, clk, rst_n, out_valid_reg && (out_pos_reg != POS_INTERIOR),
        (out_reg.upper_weight == '0) && (out_reg.upper_col == out_reg.lower_col),
        "clamped result has a second column")

    // an interior result brackets two neighboring columns
    `ASSERT_SAME(a_interior_cols, clk, rst_n, out_valid_reg && (out_pos_reg == POS_INTERIOR),
        out_reg.upper_col == (out_reg.lower_col + 6'd1),
        "interior columns are not adjacent")

    // a query keeps the input side closed on the following cycle
    `ASSERT_NEXT(a_query_busy, clk, rst_n, s_accept && (s_axis_tuser[0] == FUNC_QUERY),
        !s_axis_tready, "input taken during a query")

endmodule

`default_nettype wire
